// ----- src/dsf_pkg.sv -----
// Shared types and constants of the 2:1 symmetric FIR row decimator.
// No dependencies; used by every module of the block.
package dsf_pkg;

  // pixel and coefficient formats
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned COEF_W  = 8;
  localparam int unsigned NUM_TAPS = 4;

  // pair sum is 9 bits unsigned, product of pair and coefficient fits 18 bits signed
  localparam int unsigned PAIR_W  = PIX_W + 1;
  localparam int unsigned PROD_W  = PAIR_W + COEF_W + 1;
  localparam int unsigned PSUM_W  = PROD_W + 1;
  localparam int unsigned SUM_W   = PSUM_W + 1;

  // saturating pixel counter of the row
  localparam int unsigned SEEN_W  = 3;

  // configuration port
  localparam int unsigned APB_AW  = 4;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned REG_IDX_W = 2;

  typedef logic [PIX_W-1:0]          pix_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  // coefficient values after reset, innermost pair first
  localparam coef_t COEF_RESET [NUM_TAPS] = '{
    coef_t'(8'sd56), coef_t'(8'sd12), coef_t'(-8'sd3), coef_t'(-8'sd1)
  };

  // token that travels with a word down the pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } tok_t;

endpackage

// ----- src/downsample2_symmetric_fir_core.sv -----
// Top level of the 2:1 symmetric 8-tap row decimator; depends on dsf_pkg,
// dsf_tap_cell and dsf_sum_clip.

// The block takes one pixel per cycle while its output side keeps up. The pixel
// window is a chain of four cells, each holding one symmetric pair; the first
// pixel of a row fills every cell and each later pixel moves the chain one place.
// Output i leaves the block through the products, the first adder level and the
// output register after pixel 2i+4 is taken. After the last pixel of a row the
// input is held off while the chain shifts the last pixel in again to emit the
// remaining outputs, so a row of n pixels yields ceil(n/2) words.
// Coefficients sit at byte addresses 0, 4, 8 and 12 and must only be written
// while the block is idle.
module downsample2_symmetric_fir_core #(
  parameter int unsigned ROUND_SHIFT = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dsf_pkg::APB_AW-1:0]    paddr,
  input  logic [dsf_pkg::APB_DW-1:0]    pwdata,
  output logic [dsf_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    pixel_in_i,
  input  logic                          row_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    pixel_out_o,
  output logic                          out_last_o
);
  import dsf_pkg::*;

  coef_t              coef_q [NUM_TAPS];
  logic [REG_IDX_W-1:0] reg_idx;
  logic               cfg_wr;

  logic [SEEN_W-1:0]  seen_q;
  logic               parity_q, flush_q;
  logic [1:0]         fcnt_q;
  tok_t               tok1_q, tok2_q;

  logic               sum_ready, adv2, shift_ok, accept, step, fill, emit, capture;
  pix_t               lo [NUM_TAPS];
  pix_t               hi [NUM_TAPS];
  prod_t              prod [NUM_TAPS];

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[REG_IDX_W+1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = APB_DW'({coef_q[reg_idx]} & {COEF_W{1'b1}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= COEF_RESET;
    end else if (cfg_wr) begin
      coef_q[reg_idx] <= coef_t'(pwdata[COEF_W-1:0]);
    end
  end

  // stage handshakes
  assign adv2       = !tok2_q.valid || sum_ready;
  assign shift_ok   = !tok1_q.valid || adv2;
  assign in_ready_o = !flush_q && shift_ok;
  assign accept     = in_valid_i && in_ready_o;
  assign step       = accept || (flush_q && shift_ok);
  assign fill       = accept && (seen_q == '0);
  assign emit       = !parity_q && seen_q[SEEN_W-1];
  assign capture    = tok1_q.valid && adv2;

  // row position, parity and end-of-row flush counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= '0;
      parity_q <= 1'b0;
      flush_q  <= 1'b0;
      fcnt_q   <= '0;
    end else if (step) begin
      if (flush_q && (fcnt_q == 2'd3)) begin
        seen_q   <= '0;
        parity_q <= 1'b0;
        flush_q  <= 1'b0;
      end else begin
        if (seen_q != '1) begin
          seen_q <= seen_q + SEEN_W'(1);
        end
        parity_q <= !parity_q;
        if (flush_q) begin
          fcnt_q <= fcnt_q + 2'd1;
        end else if (row_end_i) begin
          flush_q <= 1'b1;
          fcnt_q  <= '0;
        end
      end
    end
  end

  // window stage token: one word per even position once the window is primed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok1_q <= '0;
    end else if (step) begin
      tok1_q.valid <= emit;
      tok1_q.last  <= flush_q && fcnt_q[1];
    end else if (adv2) begin
      tok1_q.valid <= 1'b0;
    end
  end

  // product stage token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok2_q <= '0;
    end else if (adv2) begin
      tok2_q.valid <= tok1_q.valid;
      tok2_q.last  <= tok1_q.last;
    end
  end

  // chain of pair cells: low pixels move outward, high pixels move inward
  for (genvar j = 0; j < NUM_TAPS; j++) begin : g_cell
    pix_t lo_in, hi_in;
    if (j == 0) begin : g_inner
      assign lo_in = hi[0];
    end else begin : g_lo
      assign lo_in = lo[j-1];
    end
    if (j == NUM_TAPS - 1) begin : g_outer
      assign hi_in = flush_q ? hi[j] : pixel_in_i;
    end else begin : g_hi
      assign hi_in = hi[j+1];
    end

    dsf_tap_cell u_cell (
      .clk_i     (clk_i),
      .shift_i   (step && !fill),
      .fill_i    (fill),
      .fill_px_i (pixel_in_i),
      .lo_in_i   (lo_in),
      .hi_in_i   (hi_in),
      .capture_i (capture),
      .coef_i    (coef_q[j]),
      .lo_o      (lo[j]),
      .hi_o      (hi[j]),
      .prod_o    (prod[j])
    );
  end

  // adder tree, rounding and output register
  dsf_sum_clip #(
    .ROUND_SHIFT (ROUND_SHIFT)
  ) u_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tok_i    (tok2_q),
    .prod_i      (prod),
    .in_ready_o  (sum_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_out_o (pixel_out_o),
    .out_last_o  (out_last_o)
  );

endmodule

// ----- src/dsf_tap_cell.sv -----
// One cell of the folded pixel chain: holds the two pixels of one symmetric pair,
// passes them to its neighbors and multiplies their sum by the pair's weight.
// Depends on dsf_pkg.
module dsf_tap_cell (
  input  logic           clk_i,
  input  logic           shift_i,
  input  logic           fill_i,
  input  dsf_pkg::pix_t  fill_px_i,
  input  dsf_pkg::pix_t  lo_in_i,
  input  dsf_pkg::pix_t  hi_in_i,
  input  logic           capture_i,
  input  dsf_pkg::coef_t coef_i,
  output dsf_pkg::pix_t  lo_o,
  output dsf_pkg::pix_t  hi_o,
  output dsf_pkg::prod_t prod_o
);
  import dsf_pkg::*;

  pix_t  lo_q, hi_q;
  prod_t prod_q;
  logic [PAIR_W-1:0] pair;
  prod_t prod_d;

  // pixel pair: fill at row start, otherwise move one place along the chain
  always_ff @(posedge clk_i) begin
    if (fill_i) begin
      lo_q <= fill_px_i;
      hi_q <= fill_px_i;
    end else if (shift_i) begin
      lo_q <= lo_in_i;
      hi_q <= hi_in_i;
    end
  end

  // pre-add and weight
  assign pair   = {1'b0, lo_q} + {1'b0, hi_q};
  assign prod_d = PROD_W'($signed({1'b0, pair})) * PROD_W'(coef_i);

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      prod_q <= prod_d;
    end
  end

  assign lo_o   = lo_q;
  assign hi_o   = hi_q;
  assign prod_o = prod_q;

endmodule

// ----- src/dsf_sum_clip.sv -----
// Adder tree, rounding shift and clip to 0..255, with the output register.
// Two stages with their own valid bits; depends on dsf_pkg.
module dsf_sum_clip #(
  parameter int unsigned ROUND_SHIFT = 7
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dsf_pkg::tok_t  in_tok_i,
  input  dsf_pkg::prod_t prod_i [dsf_pkg::NUM_TAPS],
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dsf_pkg::pix_t  pixel_out_o,
  output logic           out_last_o
);
  import dsf_pkg::*;

  localparam logic signed [SUM_W-1:0] ROUND_ADD = SUM_W'(1) << (ROUND_SHIFT - 1);

  logic signed [PSUM_W-1:0] psum_lo_q, psum_hi_q;
  tok_t                     tok_q;
  logic                     out_valid_q, out_last_q;
  pix_t                     pix_q;
  logic                     adv_out, take_in;
  logic signed [SUM_W-1:0]  sum, shifted;
  pix_t                     pix_d;

  assign adv_out    = !out_valid_q || out_ready_i;
  assign in_ready_o = !tok_q.valid || adv_out;
  assign take_in    = in_tok_i.valid && in_ready_o;

  // first adder level
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      psum_lo_q <= PSUM_W'(prod_i[0]) + PSUM_W'(prod_i[1]);
      psum_hi_q <= PSUM_W'(prod_i[2]) + PSUM_W'(prod_i[3]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (in_ready_o) begin
      tok_q.valid <= in_tok_i.valid;
      tok_q.last  <= in_tok_i.last;
    end
  end

  // final add, floor shift and clip
  always_comb begin
    sum     = SUM_W'(psum_lo_q) + SUM_W'(psum_hi_q) + ROUND_ADD;
    shifted = sum >>> ROUND_SHIFT;
    if (shifted[SUM_W-1]) begin
      pix_d = '0;
    end else if (shifted > SUM_W'(255)) begin
      pix_d = '1;
    end else begin
      pix_d = shifted[PIX_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_out) begin
      out_valid_q <= tok_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && tok_q.valid) begin
      pix_q      <= pix_d;
      out_last_q <= tok_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pix_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- src/dsf_checker.sv -----
// Port-level checks of the row decimator, bound to the top level.
// Depends on dsf_pkg and downsample2_symmetric_fir_core.
module dsf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [dsf_pkg::APB_AW-1:0] paddr,
  input logic [dsf_pkg::APB_DW-1:0] pwdata,
  input logic [dsf_pkg::APB_DW-1:0] prdata,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       row_end_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [7:0]                 pixel_out_o,
  input logic                       out_last_o
);
  import dsf_pkg::*;

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(pixel_out_o) && $stable(out_last_o))
    else $error("output word changed while stalled");

  // end of row blocks the input for the four flush shifts
  a_flush_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && row_end_i |=>
      !in_ready_o ##1 !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)
    else $error("input taken during row flush");

  // a written coefficient reads back at once
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite ##1 psel && !pwrite && paddr == $past(paddr) |->
      prdata[COEF_W-1:0] == $past(pwdata[COEF_W-1:0]))
    else $error("coefficient readback mismatch");

endmodule

bind downsample2_symmetric_fir_core dsf_checker u_dsf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .row_end_i   (row_end_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .pixel_out_o (pixel_out_o),
  .out_last_o  (out_last_o)
);
